// ===== sv/dag_edge_insert_checker_macros.svh =====
// assertion macros for the edge insertion checker
// used by the bound checker module only, no other dependencies
`ifndef DAG_EDGE_INSERT_CHECKER_MACROS_SVH
`define DAG_EDGE_INSERT_CHECKER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DAGEI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dagei assertion failed");

// next-cycle implication, disabled while reset is low
`define DAGEI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dagei assertion failed");

`endif

// ===== sv/dagei_pkg.sv =====
// shared types and codes for the dag edge insertion checker
// no dependencies; used by the checker and its assertion module
`timescale 1ns / 1ps
`default_nettype none

package dagei_pkg;

    typedef enum logic [2:0] {
        OP_ADD        = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_REVERSE    = 3'd2,
        OP_CLR_VERTEX = 3'd3,
        OP_CLR_ALL    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_LIMIT   = 3'd1,
        ST_DUP     = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_BLANKET = 3'd4,
        ST_CYCLE   = 3'd5,
        ST_BADV    = 3'd6
    } t_status;

    // configuration register indexes
    localparam logic [1:0] CFG_ACYCLIC   = 2'd0;
    localparam logic [1:0] CFG_BLANKET   = 2'd1;
    localparam logic [1:0] CFG_MAX_EDGES = 2'd2;
    localparam logic [1:0] CFG_VCOUNT    = 2'd3;

    // configuration reset values
    localparam logic       RST_ACYCLIC   = 1'b1;
    localparam logic       RST_BLANKET   = 1'b0;
    localparam logic [4:0] RST_MAX_EDGES = 5'd0;
    localparam logic [4:0] RST_VCOUNT    = 5'd16;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] source_vertex;
        logic [3:0] target_vertex;
    } t_item;

    typedef struct packed {
        logic    accepted;
        t_status status;
    } t_result;

    typedef struct packed {
        logic [1:0] index;
        logic [4:0] data;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/dagei_if.sv =====
// valid/ready channel carrying one payload of a given type
// payload types come from dagei_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dagei_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/dag_edge_insert_checker.sv =====
// dag edge insertion checker: adjacency matrix, edit sequencer, reachability unit
// depends on dagei_pkg and dagei_if
// usage
//   i_item   : edit requests (operation, source_vertex, target_vertex)
//   o_result : one result per request (accepted, status)
//   i_cfg    : register writes (index, data), always ready; write only while idle
// timing
//   a request is taken when i_item.ready is high, which is only while the
//   sequencer sits idle; ready drops the cycle after a request is taken
//   bad vertex, absent, remove, clear and unknown ops: decode, then finish,
//   which loads the output register; add / reverse settled without a search
//   (cycle check off, or refused on limit, duplicate, blanket or self edge):
//   decode, add check, finish; add / reverse with a search: decode, add check,
//   one reach step per frontier expansion (reach set rows ORed), then finish
//   the next request is taken the cycle after the result is loaded
// reset and stall
//   reset clears the graph, the edge counters and the sequencer, and loads the
//   register defaults (cycle check on, blanket rule off, no limit, 16 vertices)
//   the result sits in an output register until taken; a new request is taken
//   meanwhile, and the next result waits in the sequencer until that slot frees
`timescale 1ns / 1ps
`default_nettype none

module dag_edge_insert_checker #(
    parameter int MAX_VERTICES = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dagei_if.sink    i_item,
    dagei_if.source  o_result,
    dagei_if.sink    i_cfg
);

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_ADD    = 5'b00100,
        S_REACH  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    // matrix write port commands
    typedef enum logic [2:0] {
        WR_NONE,
        WR_SET,
        WR_CLR,
        WR_ROW,
        WR_ALL
    } t_wr;

    // configuration registers
    logic       r_acyclic;
    logic       r_blanket;
    logic [4:0] r_max_edges;
    logic [4:0] r_vcount;

    // graph storage: row is origin, bit is destination, plus per-row edge count
    logic [MAX_VERTICES-1:0] r_matrix [MAX_VERTICES];
    logic [CW-1:0]           r_count  [MAX_VERTICES];

    // sequencer registers
    t_state                  r_state, n_state;
    logic [2:0]              r_op, n_op;
    logic [3:0]              r_s, n_s;
    logic [3:0]              r_t, n_t;
    logic [IW-1:0]           r_a, n_a;          // origin of the edge being added
    logic [IW-1:0]           r_b, n_b;          // destination of the edge being added
    logic                    r_restore, n_restore;
    logic [MAX_VERTICES-1:0] r_reach, n_reach;
    logic                    r_acc, n_acc;
    dagei_pkg::t_status      r_st, n_st;

    // output register
    logic                    r_out_valid, n_out_valid;
    dagei_pkg::t_result      r_out, n_out;

    // write port
    t_wr                     w_kind;
    logic [IW-1:0]           w_row;
    logic [IW-1:0]           w_col;

    // decode helpers
    logic                    v_s_ok, v_t_ok;
    logic [IW-1:0]           v_s_idx, v_t_idx;
    logic                    v_limit;
    logic [MAX_VERTICES-1:0] v_expand;
    logic                    v_fail, v_pass;
    dagei_pkg::t_status      v_fail_st;

    assign i_item.ready     = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    // id range check against both the register and the storage depth
    assign v_s_ok  = (5'(r_s) < r_vcount) && (int'(r_s) < MAX_VERTICES);
    assign v_t_ok  = (5'(r_t) < r_vcount) && (int'(r_t) < MAX_VERTICES);
    assign v_s_idx = IW'(r_s);
    assign v_t_idx = IW'(r_t);

    // outgoing limit on the origin of the pending add, zero means none
    assign v_limit = (r_max_edges != 5'd0) && (int'(r_count[r_a]) >= int'(r_max_edges));

    // shared reachability unit: one frontier expansion per cycle
    always_comb begin
        v_expand = r_reach;
        for (int v = 0; v < MAX_VERTICES; v++) begin
            if (r_reach[v]) begin
                v_expand = v_expand | r_matrix[v];
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_s         = r_s;
        n_t         = r_t;
        n_a         = r_a;
        n_b         = r_b;
        n_restore   = r_restore;
        n_reach     = r_reach;
        n_acc       = r_acc;
        n_st        = r_st;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_result.ready;
        w_kind      = WR_NONE;
        w_row       = r_a;
        w_col       = r_b;
        v_fail      = 1'b0;
        v_pass      = 1'b0;
        v_fail_st   = dagei_pkg::ST_OK;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_op    = i_item.payload.operation;
                    n_s     = i_item.payload.source_vertex;
                    n_t     = i_item.payload.target_vertex;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_acc     = 1'b0;
                n_st      = dagei_pkg::ST_OK;
                n_restore = 1'b0;
                n_state   = S_FINISH;
                case (r_op)
                    dagei_pkg::OP_ADD: begin
                        if (!(v_s_ok && v_t_ok)) begin
                            n_st = dagei_pkg::ST_BADV;
                        end else begin
                            n_a     = v_s_idx;
                            n_b     = v_t_idx;
                            n_state = S_ADD;
                        end
                    end
                    dagei_pkg::OP_REMOVE, dagei_pkg::OP_REVERSE: begin
                        if (!(v_s_ok && v_t_ok)) begin
                            n_st = dagei_pkg::ST_BADV;
                        end else if (!r_matrix[v_s_idx][v_t_idx]) begin
                            n_st = dagei_pkg::ST_ABSENT;
                        end else begin
                            w_kind = WR_CLR;
                            w_row  = v_s_idx;
                            w_col  = v_t_idx;
                            if (r_op == dagei_pkg::OP_REVERSE) begin
                                // try the flipped edge; put this one back on refusal
                                n_a       = v_t_idx;
                                n_b       = v_s_idx;
                                n_restore = 1'b1;
                                n_state   = S_ADD;
                            end else begin
                                n_acc = 1'b1;
                            end
                        end
                    end
                    dagei_pkg::OP_CLR_VERTEX: begin
                        if (!v_s_ok) begin
                            n_st = dagei_pkg::ST_BADV;
                        end else begin
                            w_kind = WR_ROW;
                            w_row  = v_s_idx;
                            n_acc  = 1'b1;
                        end
                    end
                    dagei_pkg::OP_CLR_ALL: begin
                        w_kind = WR_ALL;
                        n_acc  = 1'b1;
                    end
                    default: begin
                        // unused op codes leave the graph alone
                        n_acc = 1'b0;
                    end
                endcase
            end

            S_ADD: begin
                if (v_limit) begin
                    v_fail    = 1'b1;
                    v_fail_st = dagei_pkg::ST_LIMIT;
                end else if (r_matrix[r_a][r_b]) begin
                    v_fail    = 1'b1;
                    v_fail_st = dagei_pkg::ST_DUP;
                end else if (r_blanket && (r_a != '0) && (r_b != '0) && !r_matrix[r_a][0]) begin
                    v_fail    = 1'b1;
                    v_fail_st = dagei_pkg::ST_BLANKET;
                end else if (r_acyclic) begin
                    if (r_a == r_b) begin
                        // self edge always closes a cycle
                        v_fail    = 1'b1;
                        v_fail_st = dagei_pkg::ST_CYCLE;
                    end else begin
                        // search from the destination for the origin
                        n_reach = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << r_b;
                        n_state = S_REACH;
                    end
                end else begin
                    v_pass = 1'b1;
                end
            end

            S_REACH: begin
                if (v_expand[r_a]) begin
                    v_fail    = 1'b1;
                    v_fail_st = dagei_pkg::ST_CYCLE;
                end else if (v_expand == r_reach) begin
                    // closure reached without the origin
                    v_pass = 1'b1;
                end else begin
                    n_reach = v_expand;
                end
            end

            S_FINISH: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out.accepted = r_acc;
                    n_out.status   = r_st;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // common exits of the add check
        if (v_pass) begin
            w_kind  = WR_SET;
            w_row   = r_a;
            w_col   = r_b;
            n_acc   = 1'b1;
            n_st    = dagei_pkg::ST_OK;
            n_state = S_FINISH;
        end else if (v_fail) begin
            if (r_restore) begin
                w_kind = WR_SET;
                w_row  = r_b;
                w_col  = r_a;
            end
            n_acc   = 1'b0;
            n_st    = v_fail_st;
            n_state = S_FINISH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_s       <= n_s;
        r_t       <= n_t;
        r_a       <= n_a;
        r_b       <= n_b;
        r_restore <= n_restore;
        r_reach   <= n_reach;
        r_acc     <= n_acc;
        r_st      <= n_st;
        r_out     <= n_out;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acyclic   <= dagei_pkg::RST_ACYCLIC;
            r_blanket   <= dagei_pkg::RST_BLANKET;
            r_max_edges <= dagei_pkg::RST_MAX_EDGES;
            r_vcount    <= dagei_pkg::RST_VCOUNT;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                dagei_pkg::CFG_ACYCLIC:   r_acyclic   <= i_cfg.payload.data[0];
                dagei_pkg::CFG_BLANKET:   r_blanket   <= i_cfg.payload.data[0];
                dagei_pkg::CFG_MAX_EDGES: r_max_edges <= i_cfg.payload.data;
                dagei_pkg::CFG_VCOUNT:    r_vcount    <= i_cfg.payload.data;
                default: begin
                    r_acyclic <= r_acyclic;
                end
            endcase
        end
    end

    // matrix and edge counters, one write per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_matrix[i] <= '0;
                r_count[i]  <= '0;
            end
        end else begin
            case (w_kind)
                WR_SET: begin
                    r_matrix[w_row][w_col] <= 1'b1;
                    r_count[w_row]         <= r_count[w_row] + CW'(1);
                end
                WR_CLR: begin
                    r_matrix[w_row][w_col] <= 1'b0;
                    r_count[w_row]         <= r_count[w_row] - CW'(1);
                end
                WR_ROW: begin
                    r_matrix[w_row] <= '0;
                    r_count[w_row]  <= '0;
                end
                WR_ALL: begin
                    for (int i = 0; i < MAX_VERTICES; i++) begin
                        r_matrix[i] <= '0;
                        r_count[i]  <= '0;
                    end
                end
                default: begin
                    r_count[w_row] <= r_count[w_row];
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/dagei_sva.sv =====
// port-level assertions for the dag edge insertion checker, with its bind
// depends on dagei_pkg and dag_edge_insert_checker_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "dag_edge_insert_checker_macros.svh"

module dagei_sva (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_accepted,
    input logic [2:0] i_out_status
);

    logic       v_out_stall;
    logic       v_out_acc;
    logic [3:0] v_out_word;

    assign v_out_stall = i_out_valid && !i_out_ready;
    assign v_out_acc   = i_out_valid && i_out_accepted;
    assign v_out_word  = {i_out_accepted, i_out_status};

    // a result waiting on the receiver stays put
    `DAGEI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, v_out_stall, i_out_valid)
    `DAGEI_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, v_out_stall, $stable(v_out_word))

    // sequencer goes busy right after taking a request
    `DAGEI_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // an accepted edit always reports ok
    `DAGEI_ASSERT_IMPL(a_accept_ok, i_clk, i_rst_n, v_out_acc, i_out_status == dagei_pkg::ST_OK)

endmodule

bind dag_edge_insert_checker dagei_sva u_dagei_sva (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_accepted (o_result.payload.accepted),
    .i_out_status   (o_result.payload.status)
);

`default_nettype wire
